@@ rtl/wlr_pkg.sv @@
// Package for the wrench low-pass rotate unit: widths, item kinds, helpers.
// No dependencies.
package wlr_pkg;
  localparam int unsigned ValW   = 24;
  localparam int unsigned QuatW  = 16;
  localparam int unsigned AlphaW = 16;
  localparam int unsigned NumCh  = 6;
  localparam int unsigned NumMat = 9;
  localparam logic [AlphaW-1:0] AlphaReset = 16'd4800;
  localparam logic [AlphaW-1:0] AlphaOne   = 16'd32768;
  localparam logic signed [QuatW-1:0] MatOne = 16'sd16384;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_POSE   = 2'd1,
    KIND_TICK   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0]              kind;
    logic signed [ValW-1:0]  force_x;
    logic signed [ValW-1:0]  force_y;
    logic signed [ValW-1:0]  force_z;
    logic signed [ValW-1:0]  torque_x;
    logic signed [ValW-1:0]  torque_y;
    logic signed [ValW-1:0]  torque_z;
    logic signed [QuatW-1:0] quat_x;
    logic signed [QuatW-1:0] quat_y;
    logic signed [QuatW-1:0] quat_z;
    logic signed [QuatW-1:0] quat_w;
  } item_t;

  typedef struct packed {
    logic signed [ValW-1:0] global_force_x;
    logic signed [ValW-1:0] global_force_y;
    logic signed [ValW-1:0] global_force_z;
    logic signed [ValW-1:0] global_torque_x;
    logic signed [ValW-1:0] global_torque_y;
    logic signed [ValW-1:0] global_torque_z;
  } result_t;

  // lane control from the sequencer
  typedef struct packed {
    logic filt_en;  // multiply alpha*diff, update filtered value
    logic rot_clr;  // clear rotation accumulator
    logic rot_en;   // accumulate one matrix term
    logic [1:0] col; // matrix column
  } lane_ctl_t;

  function automatic logic signed [ValW-1:0] sat24(input logic signed [47:0] v);
    if (v > 48'sd8388607) return 24'sh7fffff;
    else if (v < -48'sd8388608) return 24'sh800000;
    else return v[ValW-1:0];
  endfunction

  function automatic logic signed [QuatW-1:0] sat16(input logic signed [35:0] v);
    if (v > 36'sd32767) return 16'sh7fff;
    else if (v < -36'sd32768) return 16'sh8000;
    else return v[QuatW-1:0];
  endfunction
endpackage

@@ rtl/wlr_if.sv @@
// Valid/ready channel interface carrying one payload type.
// Depends on wlr_pkg for the payload types.
interface wlr_item_if;
  import wlr_pkg::*;
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface wlr_result_if;
  import wlr_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface wlr_cfg_if;
  import wlr_pkg::*;
  logic              valid;
  logic              ready;
  logic [AlphaW-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/wlr_lane.sv @@
// One channel lane: filtered state, alpha multiply, and rotation MAC.
// Depends on wlr_pkg.
module wlr_lane (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  wlr_pkg::lane_ctl_t              ctl_i,
  input  logic [wlr_pkg::AlphaW-1:0]      alpha_i,
  input  logic signed [wlr_pkg::ValW-1:0] latest_i,
  input  logic signed [wlr_pkg::QuatW-1:0] mat_i,
  input  logic signed [wlr_pkg::ValW-1:0] vec_i,
  output logic signed [wlr_pkg::ValW-1:0] filt_o,
  output logic signed [wlr_pkg::ValW-1:0] rot_o
);
  import wlr_pkg::*;

  logic signed [ValW-1:0] filt_q, filt_d;
  logic signed [43:0]     acc_q, acc_d;
  logic signed [ValW:0]   diff;
  logic signed [42:0]     prod;
  logic signed [43:0]     step_sum;
  logic signed [39:0]     term;
  logic signed [47:0]     rnd;

  assign diff = {latest_i[ValW-1], latest_i} - {filt_q[ValW-1], filt_q};
  assign prod = $signed({1'b0, alpha_i}) * diff;
  assign step_sum = {{1{prod[42]}}, prod} + 44'sd16384;

  always_comb begin
    filt_d = filt_q;
    if (ctl_i.filt_en) begin
      filt_d = sat24(48'(filt_q) + 48'(step_sum >>> 15));
    end
  end

  assign term = mat_i * vec_i;
  always_comb begin
    acc_d = acc_q;
    if (ctl_i.rot_clr) acc_d = '0;
    else if (ctl_i.rot_en) acc_d = acc_q + 44'(term);
  end

  assign rnd = (48'(acc_q) + 48'sd8192) >>> 14;
  assign rot_o = sat24(rnd);
  assign filt_o = filt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q <= '0;
    end else begin
      filt_q <= filt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end
endmodule

@@ rtl/wlr_pose.sv @@
// Quaternion to rotation matrix, one element per cycle, held in registers.
// Depends on wlr_pkg.
module wlr_pose (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [wlr_pkg::QuatW-1:0]    qx_i,
  input  logic signed [wlr_pkg::QuatW-1:0]    qy_i,
  input  logic signed [wlr_pkg::QuatW-1:0]    qz_i,
  input  logic signed [wlr_pkg::QuatW-1:0]    qw_i,
  output logic                                busy_o,
  output logic signed [wlr_pkg::QuatW-1:0]    mat_o [wlr_pkg::NumMat]
);
  import wlr_pkg::*;

  logic [3:0] idx_q;
  logic       busy_q;
  logic signed [QuatW-1:0] a1, b1, a2, b2, mat_q [NumMat];
  logic sub1, sub2, diag;
  logic signed [31:0] p1, p2;
  logic signed [35:0] sum, rnd;

  // element selection: diag = 2^27 - p1 - p2, else p1 +/- p2
  always_comb begin
    a1 = qx_i; b1 = qy_i; a2 = qw_i; b2 = qz_i; sub2 = 1'b0; diag = 1'b0;
    unique case (idx_q)
      4'd0: begin a1 = qy_i; b1 = qy_i; a2 = qz_i; b2 = qz_i; diag = 1'b1; end
      4'd1: begin a1 = qx_i; b1 = qy_i; a2 = qw_i; b2 = qz_i; sub2 = 1'b1; end
      4'd2: begin a1 = qx_i; b1 = qz_i; a2 = qw_i; b2 = qy_i; end
      4'd3: begin a1 = qx_i; b1 = qy_i; a2 = qw_i; b2 = qz_i; end
      4'd4: begin a1 = qx_i; b1 = qx_i; a2 = qz_i; b2 = qz_i; diag = 1'b1; end
      4'd5: begin a1 = qy_i; b1 = qz_i; a2 = qw_i; b2 = qx_i; sub2 = 1'b1; end
      4'd6: begin a1 = qx_i; b1 = qz_i; a2 = qw_i; b2 = qy_i; sub2 = 1'b1; end
      4'd7: begin a1 = qy_i; b1 = qz_i; a2 = qw_i; b2 = qx_i; end
      4'd8: begin a1 = qx_i; b1 = qx_i; a2 = qy_i; b2 = qy_i; diag = 1'b1; end
      default: ;
    endcase
  end
  assign sub1 = diag;

  assign p1 = a1 * b1;
  assign p2 = a2 * b2;
  always_comb begin
    sum = diag ? 36'sd134217728 : '0;
    sum = sub1 ? sum - 36'(p1) : sum + 36'(p1);
    sum = (sub2 || diag) ? sum - 36'(p2) : sum + 36'(p2);
  end
  assign rnd = (sum + 36'sd4096) >>> 13;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      for (int i = 0; i < NumMat; i++) mat_q[i] <= (i % 4 == 0) ? MatOne : '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (busy_q) begin
      mat_q[idx_q] <= sat16(rnd);
      if (idx_q == 4'(NumMat - 1)) busy_q <= 1'b0;
      idx_q <= idx_q + 4'd1;
    end
  end

  assign busy_o = busy_q;
  assign mat_o  = mat_q;
endmodule

@@ rtl/wrench_lowpass_rotate_unit.sv @@
// Top level of the wrench low-pass rotate unit: sequencer, six lanes, merge.
// Depends on wlr_pkg, wlr_if, wlr_lane, wlr_pose.
//
//  channel  | dir | transaction
//  cfg_i    | in  | alpha write (16 bit, Q1.15)
//  item_i   | in  | sample, pose or tick item
//  res_o    | out | six rotated, filtered components per tick
//
// Steps: a sample is stored on acceptance; a pose computes one matrix element
// per cycle through the shared two-multiplier unit; a tick runs a filter step,
// one MAC step per matrix column in each lane, and an output load. Reset
// restores alpha 4800, zero filter state and the identity matrix. A finished
// result waits in the output register; the next item is taken once the work is
// done, even while the result stalls, but a tick waits until the previous result has gone.
module wrench_lowpass_rotate_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  wlr_cfg_if.sink     cfg_i,
  wlr_item_if.sink    item_i,
  wlr_result_if.source res_o
);
  import wlr_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPose = 3'd1;
  localparam logic [2:0] StFilt = 3'd2;
  localparam logic [2:0] StRot  = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  logic [2:0] st_q, st_d;
  logic [1:0] col_q, col_d;
  logic [AlphaW-1:0] alpha_q, alpha_eff;
  logic signed [ValW-1:0] latest_q [NumCh];
  logic signed [QuatW-1:0] qx_q, qy_q, qz_q, qw_q;
  logic signed [QuatW-1:0] mat [NumMat];
  logic signed [ValW-1:0] filt [NumCh];
  logic signed [ValW-1:0] rot [NumCh];
  logic pose_busy, pose_start, acc;
  lane_ctl_t ctl;
  logic out_valid_q;
  result_t out_q;

  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) alpha_q <= AlphaReset;
    else if (cfg_i.valid) alpha_q <= cfg_i.data;
  end
  assign alpha_eff = (alpha_q > AlphaOne) ? AlphaOne : alpha_q;

  // ticks wait for the output register to drain
  assign item_i.ready = (st_q == StIdle) &&
                        (!out_valid_q || item_i.data.kind != KIND_TICK);
  assign acc = item_i.valid && item_i.ready;
  assign pose_start = acc && item_i.data.kind == KIND_POSE;

  always_comb begin
    st_d = st_q;
    col_d = col_q;
    ctl = '0;
    ctl.col = col_q;
    unique case (st_q)
      StIdle: begin
        if (acc && item_i.data.kind == KIND_POSE) st_d = StPose;
        else if (acc && item_i.data.kind == KIND_TICK) st_d = StFilt;
      end
      StPose: if (!pose_busy) st_d = StIdle;
      StFilt: begin
        ctl.filt_en = 1'b1;
        ctl.rot_clr = 1'b1;
        col_d = 2'd0;
        st_d = StRot;
      end
      StRot: begin
        ctl.rot_en = 1'b1;
        if (col_q == 2'd2) begin
          col_d = 2'd0;
          st_d = StOut;
        end else begin
          col_d = col_q + 2'd1;
        end
      end
      StOut: st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      col_q <= '0;
      for (int i = 0; i < NumCh; i++) latest_q[i] <= '0;
    end else begin
      st_q <= st_d;
      col_q <= col_d;
      if (acc && item_i.data.kind == KIND_SAMPLE) begin
        latest_q[0] <= item_i.data.force_x;
        latest_q[1] <= item_i.data.force_y;
        latest_q[2] <= item_i.data.force_z;
        latest_q[3] <= item_i.data.torque_x;
        latest_q[4] <= item_i.data.torque_y;
        latest_q[5] <= item_i.data.torque_z;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pose_start) begin
      qx_q <= item_i.data.quat_x;
      qy_q <= item_i.data.quat_y;
      qz_q <= item_i.data.quat_z;
      qw_q <= item_i.data.quat_w;
    end
  end

  wlr_pose u_pose (
    .clk_i, .rst_ni, .start_i(pose_start),
    .qx_i(qx_q), .qy_i(qy_q), .qz_i(qz_q), .qw_i(qw_q),
    .busy_o(pose_busy), .mat_o(mat)
  );

  // lane i: row i%3 of the matrix, vector element col of its triple
  for (genvar g = 0; g < NumCh; g++) begin : g_lane
    localparam int Row  = g % 3;
    localparam int Base = (g / 3) * 3;
    wlr_lane u_lane (
      .clk_i, .rst_ni, .ctl_i(ctl), .alpha_i(alpha_eff),
      .latest_i(latest_q[g]),
      .mat_i(mat[Row * 3 + int'(col_q)]),
      .vec_i(filt[Base + int'(col_q)]),
      .filt_o(filt[g]), .rot_o(rot[g])
    );
  end

  // merge stage: gather lane results into the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (st_q == StOut) out_valid_q <= 1'b1;
    else if (res_o.ready) out_valid_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (st_q == StOut) begin
      out_q.global_force_x  <= rot[0];
      out_q.global_force_y  <= rot[1];
      out_q.global_force_z  <= rot[2];
      out_q.global_torque_x <= rot[3];
      out_q.global_torque_y <= rot[4];
      out_q.global_torque_z <= rot[5];
    end
  end
  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

`ifndef SYNTHESIS
  a_out_only_after_rot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(st_q) == StOut) else $error("result without tick");
  a_no_tick_over_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StOut) |-> !out_valid_q) else $error("result overwritten");
  a_busy_only_pose: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pose_busy |-> st_q == StPose) else $error("pose unit busy outside pose");
`endif
endmodule
